FILE: hw/rtl/rtcep_pkg.sv
// ----------------------------------------------------------------------------
// rtcep_pkg
// Types, register indexes and constants for the RTC date to epoch converter.
// ----------------------------------------------------------------------------
package rtcep_pkg;

  typedef struct packed {
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
    logic       binary_mode;
  } snapshot_t;

  typedef struct packed {
    logic signed [33:0] epoch_seconds;
    logic [11:0]        full_year;
  } result_t;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_YEAR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_OFFSET = 1'd1;

  localparam logic [11:0]        PIVOT_RESET   = 12'd2013;
  localparam logic [5:0]         PIVOT_Q_RESET = 6'd20;
  localparam logic signed [16:0] ZONE_RESET    = -17'sd28800;

  // reciprocals: x/100 ~ (x*1311)>>17, x/3 ~ (x*43691)>>17, exact over our ranges
  localparam logic [10:0] RECIP_100 = 11'd1311;
  localparam logic [15:0] RECIP_3   = 16'd43691;

  localparam logic [8:0]         MONTH_FACTOR   = 9'd367;
  localparam logic [8:0]         DAYS_PER_YEAR  = 9'd365;
  localparam logic signed [22:0] EPOCH_BIAS     = 23'sd719499;
  localparam logic signed [17:0] SECS_PER_DAY   = 18'sd86400;

  // accept edge to result strobe, in cycles
  localparam int PIPE_LATENCY = 7;

  function automatic logic [7:0] bcd_decode(input logic [7:0] b, input logic bin);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    if (bin) begin
      return b;
    end
    return lo + (hi << 3) + (hi << 1);
  endfunction

endpackage

FILE: hw/rtl/rtc_date_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// rtc_date_to_epoch_seconds
// Converts one RTC register snapshot (BCD or binary) into epoch seconds plus
// zone offset, and the widened four-digit year.
// ----------------------------------------------------------------------------
//  channel   ports                           handshake
//  input     start, busy, snapshot           taken when start && !busy
//  result    done, result                    one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_index, cfg_wdata    written when cfg_we is high
//
//  Seven register stages: one item per cycle, result strobe in step with the
//  output register. Latency is set by the day-count multiplies and the
//  seconds-per-day product. busy is high only during reset. Reset clears the
//  pipeline valid bits and loads pivot year 2013 and zone offset -28800.
// ----------------------------------------------------------------------------
module rtc_date_to_epoch_seconds (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rtcep_pkg::snapshot_t              snapshot,
  output logic                              done,
  output rtcep_pkg::result_t                result,
  input  logic                              cfg_we,
  input  logic [rtcep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtcep_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rtcep_pkg::*;

  // configuration
  logic [11:0]        pivot;
  logic [5:0]         pivot_q;
  logic signed [16:0] zone;
  logic [22:0]        pq_prod;

  // pipeline control
  logic                    accept;
  logic [PIPE_LATENCY-1:0] vld;

  // stage 1: decoded fields
  logic [7:0] s1_sec, s1_min, s1_hour, s1_day, s1_mon, s1_yr;
  logic [7:0] hour_dec;

  // stage 2: year, month shift, time of day
  logic [12:0] century;
  logic [12:0] year_sum;
  logic [12:0] year;
  logic        borrow;
  logic [18:0] hms_next;
  logic [12:0] s2_y;
  logic        s2_yneg;
  logic [7:0]  s2_mon;
  logic [7:0]  s2_day;
  logic [18:0] s2_hms;
  logic [11:0] s2_fy;

  // stage 3: products
  logic [23:0] yq_prod;
  logic [6:0]  s3_yq;
  logic [10:0] s3_y4;
  logic [16:0] s3_m367;
  logic [20:0] s3_y365;
  logic        s3_yneg;
  logic [7:0]  s3_day;
  logic [18:0] s3_hms;
  logic [11:0] s3_fy;

  // stage 4: leap term, month days
  logic [30:0]        md_prod;
  logic signed [12:0] leap_next;
  logic signed [12:0] s4_leap;
  logic [13:0]        s4_mdays;
  logic signed [22:0] s4_y365;
  logic [7:0]         s4_day;
  logic [18:0]        s4_hms;
  logic [11:0]        s4_fy;

  // stage 5: day count
  logic signed [22:0] s5_days;
  logic [18:0]        s5_hms;
  logic [11:0]        s5_fy;

  // stage 6: seconds of whole days
  logic signed [40:0] s6_prod;
  logic [18:0]        s6_hms;
  logic [11:0]        s6_fy;

  // stage 7: output register
  logic [40:0] total;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[PIPE_LATENCY-1];

  assign pq_prod = {11'd0, cfg_wdata[11:0]} * {12'd0, RECIP_100};

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot   <= PIVOT_RESET;
      pivot_q <= PIVOT_Q_RESET;
      zone    <= ZONE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIVOT_YEAR: begin
          pivot   <= cfg_wdata[11:0];
          pivot_q <= pq_prod[22:17];
        end
        REG_ZONE_OFFSET: begin
          zone <= $signed(cfg_wdata);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LATENCY-2:0], accept};
    end
  end

  // stage 1
  always_comb begin
    if (snapshot.binary_mode) begin
      hour_dec = {1'b0, snapshot.raw_hour[6:0]};
    end else begin
      hour_dec = {4'd0, snapshot.raw_hour[3:0]}
               + ({5'd0, snapshot.raw_hour[6:4]} << 3)
               + ({5'd0, snapshot.raw_hour[6:4]} << 1);
    end
  end

  always_ff @(posedge clk) begin
    s1_sec  <= bcd_decode(snapshot.raw_second, snapshot.binary_mode);
    s1_min  <= bcd_decode(snapshot.raw_minute, snapshot.binary_mode);
    s1_hour <= hour_dec;
    s1_day  <= bcd_decode(snapshot.raw_day, snapshot.binary_mode);
    s1_mon  <= bcd_decode(snapshot.raw_month, snapshot.binary_mode);
    s1_yr   <= bcd_decode(snapshot.raw_year, snapshot.binary_mode);
  end

  // stage 2
  always_comb begin
    century  = ({7'd0, pivot_q} << 6) + ({7'd0, pivot_q} << 5) + ({7'd0, pivot_q} << 2);
    year_sum = {5'd0, s1_yr} + century;
    if (year_sum < {1'b0, pivot}) begin
      year = year_sum + 13'd100;
    end else begin
      year = year_sum;
    end
    borrow   = (s1_mon <= 8'd2);
    hms_next = ({11'd0, s1_hour} << 11) + ({11'd0, s1_hour} << 10)
             + ({11'd0, s1_hour} << 9) + ({11'd0, s1_hour} << 4)
             + ({11'd0, s1_min} << 6) - ({11'd0, s1_min} << 2)
             + {11'd0, s1_sec};
  end

  always_ff @(posedge clk) begin
    s2_y    <= year - {12'd0, borrow};
    s2_yneg <= borrow && (year == 13'd0);
    s2_mon  <= borrow ? (s1_mon + 8'd10) : (s1_mon - 8'd2);
    s2_day  <= s1_day;
    s2_hms  <= hms_next;
    s2_fy   <= year[12] ? 12'hFFF : year[11:0];
  end

  // stage 3
  assign yq_prod = {11'd0, s2_y} * {13'd0, RECIP_100};

  always_ff @(posedge clk) begin
    s3_yq   <= yq_prod[23:17];
    s3_y4   <= s2_y[12:2];
    s3_m367 <= {9'd0, s2_mon} * {8'd0, MONTH_FACTOR};
    s3_y365 <= {8'd0, s2_y} * {12'd0, DAYS_PER_YEAR};
    s3_yneg <= s2_yneg;
    s3_day  <= s2_day;
    s3_hms  <= s2_hms;
    s3_fy   <= s2_fy;
  end

  // stage 4: y/4 - y/100 + y/400, with floor of year -1 giving -1
  assign md_prod = {16'd0, s3_m367[16:2]} * {15'd0, RECIP_3};

  always_comb begin
    if (s3_yneg) begin
      leap_next = -13'sd1;
    end else begin
      leap_next = $signed({2'b0, s3_y4}) - $signed({6'b0, s3_yq})
                + $signed({8'b0, s3_yq[6:2]});
    end
  end

  always_ff @(posedge clk) begin
    s4_leap  <= leap_next;
    s4_mdays <= md_prod[30:17];
    s4_y365  <= s3_yneg ? -23'sd365 : $signed({2'b0, s3_y365});
    s4_day   <= s3_day;
    s4_hms   <= s3_hms;
    s4_fy    <= s3_fy;
  end

  // stage 5
  always_ff @(posedge clk) begin
    s5_days <= 23'(s4_leap) + $signed({9'b0, s4_mdays}) + $signed({15'b0, s4_day})
             + s4_y365 - EPOCH_BIAS;
    s5_hms  <= s4_hms;
    s5_fy   <= s4_fy;
  end

  // stage 6
  always_ff @(posedge clk) begin
    s6_prod <= 41'(s5_days) * 41'(SECS_PER_DAY);
    s6_hms  <= s5_hms;
    s6_fy   <= s5_fy;
  end

  // stage 7
  assign total = s6_prod + {22'd0, s6_hms} + {{24{zone[16]}}, zone};

  always_ff @(posedge clk) begin
    result.epoch_seconds <= $signed(total[33:0]);
    result.full_year     <= s6_fy;
  end

endmodule

FILE: hw/rtl/rtcep_checker.sv
// ----------------------------------------------------------------------------
// rtcep_checker
// Port-level checks on the converter: fixed latency and clean reset.
// ----------------------------------------------------------------------------
module rtcep_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import rtcep_pkg::*;

  logic accept;

  assign accept = start && !busy;

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LATENCY done)
    else $error("accepted item gave no result strobe");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LATENCY))
    else $error("result strobe without an accepted item");

  a_reset_flushes: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe straight after reset");

endmodule

bind rtc_date_to_epoch_seconds rtcep_checker u_rtcep_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
